// File: hw/rtl/spq_pkg.sv
// shared types and constants for the stable priority queue
package spq_pkg;

    // default sizing
    localparam int SPQ_DEPTH       = 5;
    localparam int SPQ_PRIO_BITS   = 4;
    localparam int SPQ_TAG_BITS    = 16;
    localparam int SPQ_AGE_BITS    = 8;
    localparam int SPQ_CMD_BITS    = 2;
    localparam int SPQ_STATUS_BITS = 2;

    typedef enum logic [SPQ_CMD_BITS-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_CLEAR   = 2'd2
    } spq_cmd_t;

    typedef enum logic [SPQ_STATUS_BITS-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } spq_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_READ,
        S_ENQ_CHECK,
        S_DEQ_DATA,
        S_DONE
    } spq_state_t;

    // controls from the sequencer to the entry store
    typedef struct packed {
        logic wr_en;
        logic head_advance;
    } spq_store_ctrl_t;

endpackage

// File: hw/rtl/spq_store.sv
// circular entry store with a head pointer, one write and one registered read port
module spq_store #(
    parameter int DEPTH      = spq_pkg::SPQ_DEPTH,
    parameter int ENTRY_BITS = spq_pkg::SPQ_PRIO_BITS + spq_pkg::SPQ_AGE_BITS
                               + spq_pkg::SPQ_TAG_BITS,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spq_pkg::spq_store_ctrl_t     ctrl,
    input  logic [ADDR_BITS-1:0]         rd_lidx,
    input  logic [ADDR_BITS-1:0]         wr_lidx,
    input  logic [ENTRY_BITS-1:0]        wr_data,
    output logic [ENTRY_BITS-1:0]        rd_data
);

    localparam logic [ADDR_BITS:0] DEPTH_V = (ADDR_BITS + 1)'(DEPTH);

    logic [ENTRY_BITS-1:0] mem [0:DEPTH-1];
    logic [ADDR_BITS-1:0]  head_reg;
    logic [ADDR_BITS-1:0]  head_next;
    logic [ADDR_BITS:0]    rd_sum;
    logic [ADDR_BITS:0]    wr_sum;
    logic [ADDR_BITS:0]    head_sum;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [ENTRY_BITS-1:0] rd_data_reg;

    // logical slot to physical address, one wrap at most
    always_comb
    begin
        rd_sum   = {1'b0, head_reg} + {1'b0, rd_lidx};
        wr_sum   = {1'b0, head_reg} + {1'b0, wr_lidx};
        head_sum = {1'b0, head_reg} + (ADDR_BITS + 1)'(1);
        rd_sum   = (rd_sum >= DEPTH_V) ? rd_sum - DEPTH_V : rd_sum;
        wr_sum   = (wr_sum >= DEPTH_V) ? wr_sum - DEPTH_V : wr_sum;
        head_sum = (head_sum >= DEPTH_V) ? head_sum - DEPTH_V : head_sum;
        rd_addr  = rd_sum[ADDR_BITS-1:0];
        wr_addr  = wr_sum[ADDR_BITS-1:0];
        head_next = ctrl.head_advance ? head_sum[ADDR_BITS-1:0] : head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/stable_priority_queue_unit.sv
// stable priority queue: command sequencer, result register and stream ports
// sequence, from the accepted command to the registered result word: clear and the rejected
// or unused commands go straight to S_DONE, a dequeue passes through S_DEQ_DATA, an enqueue
// alternates S_ENQ_READ and S_ENQ_CHECK for each held entry with a larger priority, which
// moves back one slot, and writes the new entry from S_ENQ_CHECK, or from S_ENQ_READ when it
// lands at the head (empty queue included); S_DONE waits for a free output register
// commands: one at a time; the next is taken once the result is registered
// reset: rst_n asynchronous active low empties the queue; entry contents are not cleared
module stable_priority_queue_unit #(
    parameter int DEPTH      = spq_pkg::SPQ_DEPTH,
    parameter int PRIO_BITS  = spq_pkg::SPQ_PRIO_BITS,
    parameter int TAG_BITS   = spq_pkg::SPQ_TAG_BITS,
    localparam int AGE_BITS  = spq_pkg::SPQ_AGE_BITS,
    localparam int CNT_BITS  = $clog2(DEPTH + 1),
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int IN_BITS   = TAG_BITS + AGE_BITS + PRIO_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = CNT_BITS + TAG_BITS + AGE_BITS + PRIO_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_W-1:0]                   s_axis_tdata,  // entry_tag, entry_age, entry_priority, zero fill
    input  logic [spq_pkg::SPQ_CMD_BITS-1:0]  s_axis_tuser,  // command
    // result side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_W-1:0]                  m_axis_tdata,  // occupancy, served_tag, served_age, served_priority, zero fill
    output logic [spq_pkg::SPQ_STATUS_BITS:0] m_axis_tuser   // status, served_valid
);

    localparam int ENTRY_BITS = PRIO_BITS + AGE_BITS + TAG_BITS;
    localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(DEPTH);

    spq_pkg::spq_state_t      state_reg, state_next;
    spq_pkg::spq_store_ctrl_t store_ctrl;
    spq_pkg::spq_cmd_t        cmd;

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   idx_reg, idx_next;
    logic [CNT_BITS-1:0]   idx_m1;

    // entry being enqueued
    logic [TAG_BITS-1:0]   new_tag_reg, new_tag_next;
    logic [AGE_BITS-1:0]   new_age_reg, new_age_next;
    logic [PRIO_BITS-1:0]  new_prio_reg, new_prio_next;

    // result under construction
    spq_pkg::spq_status_t  res_status_reg, res_status_next;
    logic                  res_valid_reg, res_valid_next;
    logic [TAG_BITS-1:0]   res_tag_reg, res_tag_next;
    logic [AGE_BITS-1:0]   res_age_reg, res_age_next;
    logic [PRIO_BITS-1:0]  res_prio_reg, res_prio_next;

    // output word register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    spq_pkg::spq_status_t  out_status_reg;
    logic                  out_served_reg;
    logic [CNT_BITS-1:0]   out_count_reg;
    logic [TAG_BITS-1:0]   out_tag_reg;
    logic [AGE_BITS-1:0]   out_age_reg;
    logic [PRIO_BITS-1:0]  out_prio_reg;

    // entry store interface
    logic [ADDR_BITS-1:0]  rd_lidx;
    logic [ADDR_BITS-1:0]  wr_lidx;
    logic [ENTRY_BITS-1:0] wr_data;
    logic [ENTRY_BITS-1:0] rd_data;
    logic [PRIO_BITS-1:0]  rd_prio;
    logic [AGE_BITS-1:0]   rd_age;
    logic [TAG_BITS-1:0]   rd_tag;
    logic                  in_accept;

    assign cmd       = spq_pkg::spq_cmd_t'(s_axis_tuser);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign idx_m1    = idx_reg - 1'b1;

    // stored word layout: tag low, then age, then priority
    assign rd_tag  = rd_data[TAG_BITS-1:0];
    assign rd_age  = rd_data[TAG_BITS +: AGE_BITS];
    assign rd_prio = rd_data[TAG_BITS + AGE_BITS +: PRIO_BITS];

    spq_store #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (store_ctrl),
        .rd_lidx (rd_lidx),
        .wr_lidx (wr_lidx),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        new_tag_next    = new_tag_reg;
        new_age_next    = new_age_reg;
        new_prio_next   = new_prio_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_tag_next    = res_tag_reg;
        res_age_next    = res_age_reg;
        res_prio_next   = res_prio_reg;
        store_ctrl      = '0;
        // idle keeps the head slot on the read port so a dequeue finds it next cycle
        rd_lidx         = '0;
        wr_lidx         = idx_reg[ADDR_BITS-1:0];
        wr_data         = {new_prio_reg, new_age_reg, new_tag_reg};
        out_load        = 1'b0;

        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    new_tag_next    = s_axis_tdata[TAG_BITS-1:0];
                    new_age_next    = s_axis_tdata[TAG_BITS +: AGE_BITS];
                    new_prio_next   = s_axis_tdata[TAG_BITS + AGE_BITS +: PRIO_BITS];
                    res_status_next = spq_pkg::STAT_DONE;
                    res_valid_next  = 1'b0;
                    res_tag_next    = '0;
                    res_age_next    = '0;
                    res_prio_next   = '0;
                    state_next      = spq_pkg::S_DONE;
                    unique case (cmd)
                        spq_pkg::CMD_ENQUEUE:
                        begin
                            if (count_reg >= DEPTH_C)
                            begin
                                res_status_next = spq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                // walk from the tail towards the head
                                idx_next   = count_reg;
                                state_next = spq_pkg::S_ENQ_READ;
                            end
                        end
                        spq_pkg::CMD_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = spq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = spq_pkg::S_DEQ_DATA;
                            end
                        end
                        spq_pkg::CMD_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = spq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused code: no change, done status
                        end
                    endcase
                end
            end

            spq_pkg::S_ENQ_READ:
            begin
                if (idx_reg == '0)
                begin
                    // reached the head: new entry goes in front
                    store_ctrl.wr_en = 1'b1;
                    count_next       = count_reg + 1'b1;
                    state_next       = spq_pkg::S_DONE;
                end
                else
                begin
                    rd_lidx    = idx_m1[ADDR_BITS-1:0];
                    state_next = spq_pkg::S_ENQ_CHECK;
                end
            end

            spq_pkg::S_ENQ_CHECK:
            begin
                store_ctrl.wr_en = 1'b1;
                if (rd_prio > new_prio_reg)
                begin
                    // larger priority moves back one slot
                    wr_data    = rd_data;
                    idx_next   = idx_m1;
                    state_next = spq_pkg::S_ENQ_READ;
                end
                else
                begin
                    // equal or smaller stays ahead: insert behind it
                    count_next = count_reg + 1'b1;
                    state_next = spq_pkg::S_DONE;
                end
            end

            spq_pkg::S_DEQ_DATA:
            begin
                res_valid_next          = 1'b1;
                res_tag_next            = rd_tag;
                res_age_next            = rd_age;
                res_prio_next           = rd_prio;
                store_ctrl.head_advance = 1'b1;
                count_next              = count_reg - 1'b1;
                state_next              = spq_pkg::S_DONE;
            end

            spq_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = spq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        new_tag_reg    <= new_tag_next;
        new_age_reg    <= new_age_next;
        new_prio_reg   <= new_prio_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_tag_reg    <= res_tag_next;
        res_age_reg    <= res_age_next;
        res_prio_reg   <= res_prio_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_served_reg <= res_valid_reg;
            out_count_reg  <= count_reg;
            out_tag_reg    <= res_tag_reg;
            out_age_reg    <= res_age_reg;
            out_prio_reg   <= res_prio_reg;
        end
    end

    assign s_axis_tready = (state_reg == spq_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_prio_reg, out_age_reg, out_tag_reg, out_count_reg});
    assign m_axis_tuser  = {out_served_reg, out_status_reg};

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("occupancy above depth");

    // an insertion walk only runs with a free slot
    a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::S_ENQ_READ || state_reg == spq_pkg::S_ENQ_CHECK)
        |-> count_reg < DEPTH_C)
        else $error("insertion walk on a full queue");

    // a served head always removes exactly one entry
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spq_pkg::S_DEQ_DATA |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not drop occupancy by one");

    // a served entry comes only with a done status
    a_served_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_served_reg) |-> out_status_reg == spq_pkg::STAT_DONE)
        else $error("served entry with a reject status");

    // the walk index never points beyond the entries held
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::S_ENQ_READ || state_reg == spq_pkg::S_ENQ_CHECK)
        |-> idx_reg <= count_reg)
        else $error("insertion index beyond occupancy");

endmodule

// File: test/tb_stable_priority_queue_unit.sv
// self-checking stream testbench for the stable priority queue unit
`timescale 1ns / 1ps

module tb_stable_priority_queue_unit;

    // sizing, mirrored from the block defaults
    localparam int DEPTH     = spq_pkg::SPQ_DEPTH;
    localparam int PRIO_BITS = spq_pkg::SPQ_PRIO_BITS;
    localparam int TAG_BITS  = spq_pkg::SPQ_TAG_BITS;
    localparam int AGE_BITS  = spq_pkg::SPQ_AGE_BITS;
    localparam int CMD_BITS  = spq_pkg::SPQ_CMD_BITS;
    localparam int STAT_BITS = spq_pkg::SPQ_STATUS_BITS;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int IN_BITS   = TAG_BITS + AGE_BITS + PRIO_BITS;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = CNT_BITS + TAG_BITS + AGE_BITS + PRIO_BITS;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    // the fourth command code has no meaning and must leave the queue alone
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    localparam int CLK_HALF      = 6;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off for the backpressure test
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_GUARD   = 20000;

    typedef struct {
        spq_pkg::spq_status_t status;
        logic [CNT_BITS-1:0]  occupancy;
        logic                 served_valid;
        logic [TAG_BITS-1:0]  served_tag;
        logic [AGE_BITS-1:0]  served_age;
        logic [PRIO_BITS-1:0] served_prio;
    } queue_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_W-1:0]               s_axis_tdata  = '0;  // entry_tag, entry_age, entry_priority, zero fill
    logic [CMD_BITS-1:0]           s_axis_tuser  = '0;  // command
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [OUT_W-1:0]              m_axis_tdata;        // occupancy, served_tag, served_age, served_priority, zero fill
    logic [STAT_BITS:0]            m_axis_tuser;        // status, served_valid

    // idling controls, changed only at clock edges
    logic tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;
    logic rx_hold    = 1'b0;

    // predicted queue contents, slot 0 is the head
    logic [PRIO_BITS-1:0] held_prio [DEPTH];
    logic [TAG_BITS-1:0]  held_tag  [DEPTH];
    logic [AGE_BITS-1:0]  held_age  [DEPTH];
    int                   held_count = 0;

    queue_result_t awaited_results [$];
    int            fail_count = 0;

    stable_priority_queue_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_HALF) clk = ~clk;

    // apply one accepted command to the predicted queue and queue up its result word
    task automatic apply_queue_command(input logic [CMD_BITS-1:0] cmd,
                                       input logic [TAG_BITS-1:0] tag,
                                       input logic [AGE_BITS-1:0] age,
                                       input logic [PRIO_BITS-1:0] prio);
        queue_result_t res;
        int            pos;
        res.status       = spq_pkg::STAT_DONE;
        res.served_valid = 1'b0;
        res.served_tag   = '0;
        res.served_age   = '0;
        res.served_prio  = '0;
        if (cmd == spq_pkg::CMD_ENQUEUE)
        begin
            if (held_count >= DEPTH)
                res.status = spq_pkg::STAT_FULL;
            else
            begin
                // new entry goes behind every entry of equal or better priority
                pos = 0;
                while (pos < held_count && held_prio[pos] <= prio)
                    pos++;
                for (int i = held_count; i > pos; i--)
                begin
                    held_prio[i] = held_prio[i-1];
                    held_tag[i]  = held_tag[i-1];
                    held_age[i]  = held_age[i-1];
                end
                held_prio[pos] = prio;
                held_tag[pos]  = tag;
                held_age[pos]  = age;
                held_count++;
            end
        end
        else if (cmd == spq_pkg::CMD_DEQUEUE)
        begin
            if (held_count == 0)
                res.status = spq_pkg::STAT_EMPTY;
            else
            begin
                res.served_valid = 1'b1;
                res.served_tag   = held_tag[0];
                res.served_age   = held_age[0];
                res.served_prio  = held_prio[0];
                for (int i = 0; i + 1 < held_count; i++)
                begin
                    held_prio[i] = held_prio[i+1];
                    held_tag[i]  = held_tag[i+1];
                    held_age[i]  = held_age[i+1];
                end
                held_count--;
            end
        end
        else if (cmd == spq_pkg::CMD_CLEAR)
        begin
            if (held_count == 0)
                res.status = spq_pkg::STAT_EMPTY;
            else
                held_count = 0;
        end
        // unused code: nothing changes, status done
        res.occupancy = held_count[CNT_BITS-1:0];
        awaited_results.push_back(res);
    endtask

    // offer one command word, optionally after a random gap, and wait for it to be taken
    task automatic send_word(input logic [CMD_BITS-1:0] cmd,
                             input logic [TAG_BITS-1:0] tag,
                             input logic [AGE_BITS-1:0] age,
                             input logic [PRIO_BITS-1:0] prio);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, prio, age, tag};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_queue_command(cmd, tag, age, prio);
    endtask

    // one random command word; bias picks how often it is an enqueue
    task automatic send_random_word(input int enq_pct);
        int                       r;
        logic [CMD_BITS-1:0]      cmd;
        logic [PRIO_BITS-1:0]     prio;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            cmd = spq_pkg::CMD_ENQUEUE;
        else if (r < 95)
            cmd = spq_pkg::CMD_DEQUEUE;
        else if (r < 98)
            cmd = spq_pkg::CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        // narrow priorities half the time, so ties are common
        if ($urandom_range(0, 1) == 0)
            prio = PRIO_BITS'($urandom_range(0, 3));
        else
            prio = PRIO_BITS'($urandom_range(0, (1 << PRIO_BITS) - 1));
        send_word(cmd, TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1)),
                  AGE_BITS'($urandom_range(0, (1 << AGE_BITS) - 1)), prio);
    endtask

    // receiver: random stall bursts, or a held-off stretch while rx_hold is set
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 15) - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checker, compares each taken result word with the oldest prediction
    always @(posedge clk)
    begin
        queue_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result word with no prediction waiting: tuser %0h tdata %0h",
                       m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_res = awaited_results.pop_front();
                if (m_axis_tuser[STAT_BITS-1:0] !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           exp_res.status, m_axis_tuser[STAT_BITS-1:0]);
                    fail_count++;
                end
                if (m_axis_tuser[STAT_BITS] !== exp_res.served_valid)
                begin
                    $error("served_valid: expected %0d, actual %0d",
                           exp_res.served_valid, m_axis_tuser[STAT_BITS]);
                    fail_count++;
                end
                if (m_axis_tdata[0 +: CNT_BITS] !== exp_res.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d",
                           exp_res.occupancy, m_axis_tdata[0 +: CNT_BITS]);
                    fail_count++;
                end
                if (m_axis_tdata[CNT_BITS +: TAG_BITS] !== exp_res.served_tag)
                begin
                    $error("served_tag: expected %0h, actual %0h",
                           exp_res.served_tag, m_axis_tdata[CNT_BITS +: TAG_BITS]);
                    fail_count++;
                end
                if (m_axis_tdata[CNT_BITS + TAG_BITS +: AGE_BITS] !== exp_res.served_age)
                begin
                    $error("served_age: expected %0h, actual %0h",
                           exp_res.served_age, m_axis_tdata[CNT_BITS + TAG_BITS +: AGE_BITS]);
                    fail_count++;
                end
                if (m_axis_tdata[CNT_BITS + TAG_BITS + AGE_BITS +: PRIO_BITS]
                    !== exp_res.served_prio)
                begin
                    $error("served_priority: expected %0h, actual %0h", exp_res.served_prio,
                           m_axis_tdata[CNT_BITS + TAG_BITS + AGE_BITS +: PRIO_BITS]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_W-1:OUT_BITS] !== '0)
                begin
                    $error("tdata fill: expected 0, actual %0h", m_axis_tdata[OUT_W-1:OUT_BITS]);
                    fail_count++;
                end
            end
        end
    end

    // rejects on an empty queue straight after reset, plus the unused code
    task automatic test_empty_rejects();
        send_word(spq_pkg::CMD_DEQUEUE, '0, '0, '0);
        send_word(spq_pkg::CMD_CLEAR, '0, '0, '0);
        send_word(CMD_UNUSED, '1, '1, '1);
    endtask

    // sort order, field extremes and first-in first-out among equal priorities
    task automatic test_ordering();
        send_word(spq_pkg::CMD_ENQUEUE, 16'hffff, 8'hff, 4'hf);
        send_word(spq_pkg::CMD_ENQUEUE, 16'h0000, 8'h00, 4'h0);
        send_word(spq_pkg::CMD_ENQUEUE, 16'h00a7, 8'h11, 4'h7);
        send_word(spq_pkg::CMD_ENQUEUE, 16'h00b7, 8'h22, 4'h7);
        send_word(spq_pkg::CMD_ENQUEUE, 16'h0001, 8'h33, 4'h0);   // ties with the head, goes behind it
    endtask

    // enqueue on a full queue, unused code on a busy queue, then drain past empty
    task automatic test_full_reject();
        send_word(spq_pkg::CMD_ENQUEUE, 16'h5a5a, 8'ha5, 4'h0);
        send_word(CMD_UNUSED, 16'h1234, 8'h56, 4'h3);
        repeat (DEPTH) send_word(spq_pkg::CMD_DEQUEUE, TAG_BITS'($urandom),
                                 AGE_BITS'($urandom), PRIO_BITS'($urandom));
        send_word(spq_pkg::CMD_DEQUEUE, '0, '0, '0);
    endtask

    // clear a busy queue, then clear again when already empty
    task automatic test_clear();
        send_word(spq_pkg::CMD_ENQUEUE, 16'h0303, 8'h03, 4'h3);
        send_word(spq_pkg::CMD_ENQUEUE, 16'h0404, 8'h04, 4'h3);
        send_word(spq_pkg::CMD_CLEAR, '0, '0, '0);
        send_word(spq_pkg::CMD_CLEAR, '0, '0, '0);
        send_word(spq_pkg::CMD_ENQUEUE, 16'h0909, 8'h09, 4'h9);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering words
    task automatic test_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (12) send_random_word(70);
            end
        join
    endtask

    // random commands in blocks, each block with its own enqueue bias
    task automatic test_random(input int blocks);
        int enq_pct;
        for (int b = 0; b < blocks; b++)
        begin
            case ($urandom_range(0, 3))
                0: enq_pct = 30;
                1: enq_pct = 50;
                2: enq_pct = 70;
                default: enq_pct = 85;
            endcase
            repeat (40) send_random_word(enq_pct);
        end
    endtask

    // final stretch: back-to-back words with no idling on either side
    task automatic test_streaming();
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        test_random(8);
    endtask

    initial
    begin
        int guard;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_rejects();
        test_ordering();
        test_full_reject();
        test_clear();
        test_backpressure();
        test_random(34);
        test_streaming();

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (awaited_results.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d predicted result words never arrived", awaited_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // overall time limit, far beyond the slowest correct run
    initial
    begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
